[design/zonal_mean_accumulator_macros.svh]
// Assertion macros for the zonal mean accumulator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ZONAL_MEAN_ACCUMULATOR_MACROS_SVH
`define ZONAL_MEAN_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define ZMA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("zonal_mean_accumulator: assertion failed");
`define ZMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zonal_mean_accumulator: assertion failed");
`else
`define ZMA_ASSERT(lbl, clk, rst_n, prop)
`define ZMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/zma_pkg.sv]
// Shared types and constants for the zonal mean accumulator.
// No dependencies; imported by every module of the block.
package zma_pkg;

    localparam int PIX_W      = 32;
    localparam int SCALE_W    = 32;
    localparam int AVG_W      = 48;
    localparam int MEAN_W     = 48;
    localparam int FRAC_BITS  = 16;
    localparam int SHIFT_BITS = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [7:0] FIRST_ZONE = 8'd1;
    localparam logic [7:0] LAST_ZONE  = 8'd254;

    localparam logic signed [AVG_W-1:0] NO_DATA_AVG = -48'sd6553534464;
    localparam logic signed [AVG_W-1:0] AVG_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [AVG_W-1:0] AVG_MIN     = 48'sh8000_0000_0000;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_LABELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;

    typedef struct packed {
        logic                    operation;
        logic [7:0]              zone_label;
        logic signed [PIX_W-1:0] pixel_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]              zone_index;
        logic                    zone_seen;
        logic                    has_valid;
        logic signed [AVG_W-1:0] zone_average;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CALC,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ABS,
        A_DIV,
        A_SCL,
        A_MUL,
        A_RND,
        A_NEG,
        A_OFF
    } t_astate;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic load_out;
    } t_ctrl;

endpackage

[design/zma_store.sv]
// Per-zone storage: sum, count and seen flag in one memory word.
// Valid bits in flops make unwritten entries read as zero. Uses zma_pkg.
module zma_store import zma_pkg::*; #(
    parameter int ZONE_SLOTS = 256,
    parameter int COUNT_BITS = 24,
    localparam int ADDR_W = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1,
    localparam int SUM_W  = COUNT_BITS + PIX_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    output logic signed [SUM_W-1:0] o_rd_sum,
    output logic [COUNT_BITS-1:0]   o_rd_cnt,
    output logic                    o_rd_seen,
    input  logic                    i_wr_en,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic signed [SUM_W-1:0] i_wr_sum,
    input  logic [COUNT_BITS-1:0]   i_wr_cnt,
    input  logic                    i_wr_seen
);

    localparam int WORD_W = SUM_W + COUNT_BITS + 1;

    logic [WORD_W-1:0]     r_mem [ZONE_SLOTS];
    logic [WORD_W-1:0]     r_rd_word;
    logic                  r_rd_vld;
    logic [ZONE_SLOTS-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_seen, i_wr_cnt, i_wr_sum};
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // an entry never written reads as cleared
    assign o_rd_sum  = r_rd_vld ? signed'(r_rd_word[SUM_W-1:0]) : '0;
    assign o_rd_cnt  = r_rd_vld ? r_rd_word[SUM_W +: COUNT_BITS] : '0;
    assign o_rd_seen = r_rd_vld & r_rd_word[WORD_W-1];

endmodule

[design/zma_arith.sv]
// Iterative mean and scale unit around one shared wide adder.
// Restoring divide, shift-add multiply, rounding, offset and saturation. Uses zma_pkg.
module zma_arith import zma_pkg::*; #(
    parameter int COUNT_BITS = 24,
    localparam int SUM_W = COUNT_BITS + PIX_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [COUNT_BITS-1:0]   i_count,
    input  logic signed [SCALE_W-1:0] i_scale,
    input  logic signed [AVG_W-1:0] i_offset,
    output logic                    o_done,
    output logic signed [AVG_W-1:0] o_avg
);

    localparam int DVD_W  = SUM_W + FRAC_BITS;
    localparam int PROD_W = MEAN_W + SCALE_W;
    localparam int ADD_W  = ((DVD_W > PROD_W) ? DVD_W : PROD_W) + 2;
    localparam int STEP_W = $clog2(DVD_W + 1);

    t_astate                 r_state, n_state;
    logic [STEP_W-1:0]       r_step;
    logic [DVD_W-1:0]        r_dvd;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [COUNT_BITS-1:0]   r_cnt;
    logic [PROD_W-1:0]       r_prod;
    logic [MEAN_W-1:0]       r_mcand;
    logic [ADD_W-1:0]        r_res;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SCALE_W-1:0] r_scale;
    logic signed [AVG_W-1:0] r_offset;
    logic                    r_neg_sum;
    logic                    r_neg;
    logic signed [AVG_W-1:0] r_avg;
    logic                    r_done;

    logic [ADD_W-1:0] w_a, w_b, w_sum;
    logic             w_cin;
    logic             w_last_div, w_last_mul;
    logic             w_fits;

    assign w_last_div = (r_step == STEP_W'(DVD_W - 1));
    assign w_last_mul = (r_step == STEP_W'(SCALE_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: if (i_start) n_state = A_ABS;
            A_ABS:  n_state = A_DIV;
            A_DIV:  if (w_last_div) n_state = A_SCL;
            A_SCL:  n_state = A_MUL;
            A_MUL:  if (w_last_mul) n_state = A_RND;
            A_RND:  n_state = A_NEG;
            A_NEG:  n_state = A_OFF;
            A_OFF:  n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    // operand select for the shared adder
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_cin = 1'b0;
        case (r_state)
            A_ABS: begin
                w_a   = r_neg_sum ? ~ADD_W'(r_sum) : ADD_W'(r_sum);
                w_cin = r_neg_sum;
            end
            A_DIV: begin
                w_a   = ADD_W'({r_rem, r_dvd[DVD_W-1]});
                w_b   = ~ADD_W'(r_cnt);
                w_cin = 1'b1;
            end
            A_SCL: begin
                w_a   = r_scale[SCALE_W-1] ? ~ADD_W'(r_scale) : ADD_W'(r_scale);
                w_cin = r_scale[SCALE_W-1];
            end
            A_MUL: begin
                w_a = ADD_W'(r_prod[PROD_W-1:SCALE_W]);
                w_b = r_prod[0] ? ADD_W'(r_mcand) : '0;
            end
            A_RND: begin
                w_a = ADD_W'(r_prod);
                w_b = r_neg ? {{(ADD_W-SHIFT_BITS){1'b0}}, {SHIFT_BITS{1'b1}}} : '0;
            end
            A_NEG: begin
                w_a   = r_neg ? ~ADD_W'(r_prod[PROD_W-1:SHIFT_BITS])
                              : ADD_W'(r_prod[PROD_W-1:SHIFT_BITS]);
                w_cin = r_neg;
            end
            A_OFF: begin
                w_a = r_res;
                w_b = ADD_W'(r_offset);
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    assign w_sum  = w_a + w_b + ADD_W'(w_cin);
    assign w_fits = (&w_sum[ADD_W-1:AVG_W-1]) | ~(|w_sum[ADD_W-1:AVG_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == A_OFF);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    r_sum     <= i_sum;
                    r_cnt     <= i_count;
                    r_scale   <= i_scale;
                    r_offset  <= i_offset;
                    r_neg_sum <= i_sum[SUM_W-1];
                    r_neg     <= i_sum[SUM_W-1] ^ i_scale[SCALE_W-1];
                end
            end
            A_ABS: begin
                r_dvd  <= {w_sum[SUM_W-1:0], {FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_step <= '0;
            end
            A_DIV: begin
                if (w_sum[ADD_W-1]) begin
                    r_rem <= {r_rem[COUNT_BITS-2:0], r_dvd[DVD_W-1]};
                end else begin
                    r_rem <= w_sum[COUNT_BITS-1:0];
                end
                r_dvd  <= {r_dvd[DVD_W-2:0], ~w_sum[ADD_W-1]};
                r_step <= r_step + 1'b1;
            end
            A_SCL: begin
                r_mcand <= r_dvd[MEAN_W-1:0];
                r_prod  <= {{MEAN_W{1'b0}}, w_sum[SCALE_W-1:0]};
                r_step  <= '0;
            end
            A_MUL: begin
                r_prod <= {w_sum[MEAN_W:0], r_prod[SCALE_W-1:1]};
                r_step <= r_step + 1'b1;
            end
            A_RND: begin
                r_prod <= w_sum[PROD_W-1:0];
            end
            A_NEG: begin
                r_res <= w_sum;
            end
            A_OFF: begin
                if (w_fits) begin
                    r_avg <= signed'(w_sum[AVG_W-1:0]);
                end else begin
                    r_avg <= w_sum[ADD_W-1] ? AVG_MIN : AVG_MAX;
                end
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_avg  = r_avg;

endmodule

[design/zonal_mean_accumulator.sv]
// Zonal mean accumulator top level: sequencer, configuration registers, output register.
// Depends on zma_pkg, zma_store, zma_arith and zonal_mean_accumulator_macros.svh.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An accumulate word takes one memory read, then one read-modify-write.
// A read word of a zone with valid pixels takes the memory read, then the absolute value,
// bit-serial divide and multiply, rounding, sign and offset steps in zma_arith, then the
// output step. A read word with no valid pixels skips zma_arith and goes to the output step.
// Reset is synchronous, active low; per-zone valid bits clear all zones at once.
// A stalled result waits in the output register; the next word is taken meanwhile.
`include "zonal_mean_accumulator_macros.svh"

module zonal_mean_accumulator import zma_pkg::*; #(
    parameter int ZONE_SLOTS = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int SUM_W  = COUNT_BITS + PIX_W;

    // configuration
    logic                      r_use_labels;
    logic signed [PIX_W-1:0]   r_valid_low;
    logic signed [PIX_W-1:0]   r_valid_high;
    logic signed [SCALE_W-1:0] r_scale;
    logic signed [AVG_W-1:0]   r_offset;

    // sequencer and held item
    t_state                  r_state, n_state;
    t_ctrl                   w_ctrl;
    logic                    r_op;
    logic [7:0]              r_zone;
    logic                    r_in_range;
    logic signed [PIX_W-1:0] r_pix;
    logic                    r_res_seen;
    logic                    r_res_valid;
    logic signed [AVG_W-1:0] r_res_avg;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    logic                    w_in_acc;
    logic [7:0]              w_zone;
    logic                    w_in_range;
    logic signed [SUM_W-1:0] w_rd_sum;
    logic [COUNT_BITS-1:0]   w_rd_cnt;
    logic                    w_rd_seen;
    logic                    w_pix_ok;
    logic signed [SUM_W-1:0] w_wr_sum;
    logic [COUNT_BITS-1:0]   w_wr_cnt;
    logic                    w_wr_seen;
    logic                    w_arith_done;
    logic signed [AVG_W-1:0] w_arith_avg;
    logic                    w_out_free;
    logic                    w_look_seen;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // labels off: every pixel lands in zone 1; a read always names its zone
    assign w_zone = ((i_in_word.operation == OP_READ) || r_use_labels)
                  ? i_in_word.zone_label : FIRST_ZONE;
    assign w_in_range = (w_zone >= FIRST_ZONE) && (w_zone <= LAST_ZONE)
                     && ({1'b0, w_zone} < 9'(ZONE_SLOTS));

    assign w_out_free = !r_out_valid || !i_out_stall;

    zma_store #(
        .ZONE_SLOTS (ZONE_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_zone[ADDR_W-1:0]),
        .o_rd_sum  (w_rd_sum),
        .o_rd_cnt  (w_rd_cnt),
        .o_rd_seen (w_rd_seen),
        .i_wr_en   (w_ctrl.wr_en),
        .i_wr_addr (r_zone[ADDR_W-1:0]),
        .i_wr_sum  (w_wr_sum),
        .i_wr_cnt  (w_wr_cnt),
        .i_wr_seen (w_wr_seen)
    );

    zma_arith #(
        .COUNT_BITS (COUNT_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_ctrl.start),
        .i_sum    (w_rd_sum),
        .i_count  (w_rd_cnt),
        .i_scale  (r_scale),
        .i_offset (r_offset),
        .o_done   (w_arith_done),
        .o_avg    (w_arith_avg)
    );

    // a pixel counts only inside the valid window and while the count has headroom
    assign w_pix_ok = (r_pix >= r_valid_low) && (r_pix <= r_valid_high)
                   && (w_rd_cnt != {COUNT_BITS{1'b1}});

    // accumulate: update the entry; read: clear it
    always_comb begin
        if (r_op == OP_ACCUM) begin
            w_wr_seen = 1'b1;
            w_wr_sum  = w_pix_ok ? (w_rd_sum + SUM_W'(r_pix)) : w_rd_sum;
            w_wr_cnt  = w_pix_ok ? (w_rd_cnt + 1'b1) : w_rd_cnt;
        end else begin
            w_wr_seen = 1'b0;
            w_wr_sum  = '0;
            w_wr_cnt  = '0;
        end
    end

    // zone 1 always reads as seen when labels are off
    assign w_look_seen = r_in_range
                      && (w_rd_seen || (!r_use_labels && (r_zone == FIRST_ZONE)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (r_op == OP_ACCUM) begin
                    n_state = S_IDLE;
                end else if (r_in_range && (w_rd_cnt != '0)) begin
                    n_state = S_CALC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CALC: begin
                if (w_arith_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl = '0;
        case (r_state)
            S_LOOK: begin
                w_ctrl.wr_en = r_in_range;
                w_ctrl.start = (r_op == OP_READ) && r_in_range && (w_rd_cnt != '0);
            end
            S_OUT: begin
                w_ctrl.load_out = w_out_free;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_use_labels <= 1'b0;
            r_valid_low  <= -32'sd2000;
            r_valid_high <= 32'sd10000;
            r_scale      <= 32'sd1677;
            r_offset     <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_USE_LABELS: r_use_labels <= i_cfg_data[0];
                    CFG_VALID_LOW:  r_valid_low  <= signed'(i_cfg_data[PIX_W-1:0]);
                    CFG_VALID_HIGH: r_valid_high <= signed'(i_cfg_data[PIX_W-1:0]);
                    CFG_SCALE:      r_scale      <= signed'(i_cfg_data[SCALE_W-1:0]);
                    CFG_OFFSET:     r_offset     <= signed'(i_cfg_data[AVG_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // hold the item and the partial result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op       <= i_in_word.operation;
            r_zone     <= w_zone;
            r_in_range <= w_in_range;
            r_pix      <= i_in_word.pixel_value;
        end
        if (r_state == S_LOOK) begin
            r_res_seen  <= w_look_seen;
            r_res_valid <= r_in_range && (w_rd_cnt != '0);
            r_res_avg   <= NO_DATA_AVG;
        end
        if (w_arith_done) begin
            r_res_avg <= w_arith_avg;
        end
        if (w_ctrl.load_out) begin
            r_out_word.zone_index   <= r_zone;
            r_out_word.zone_seen    <= r_res_seen;
            r_out_word.has_valid    <= r_res_valid;
            r_out_word.zone_average <= r_res_avg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // an accepted word always goes to the memory lookup next
    `ZMA_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, w_in_acc, r_state == S_LOOK)
    // results only appear from the output step
    `ZMA_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == S_OUT)
    // the arithmetic unit only finishes while the sequencer waits for it
    `ZMA_ASSERT(a_done_in_calc, i_clk, i_rst_n, w_arith_done |-> r_state == S_CALC)
    // an accumulate word never starts the arithmetic unit
    `ZMA_ASSERT(a_accum_no_start, i_clk, i_rst_n, w_ctrl.start |-> r_op == OP_READ)

endmodule
